// ===== rtl/core/nte_pkg.sv =====
// nte_pkg: shared types, token codes and the sequencer microcode ROM for
// number_to_english_tokens. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package nte_pkg;

	localparam int NumBits  = 32;
	localparam int NumDigs  = 10;
	localparam int BcdBits  = 4 * NumDigs;
	localparam int TokBits  = 7;
	localparam int PcBits   = 4;
	localparam int CntBits  = $clog2(NumBits);

	localparam logic [TokBits-1:0] TOK_ZERO     = 7'd0;
	localparam logic [TokBits-1:0] TOK_TEN      = 7'd10;
	localparam logic [TokBits-1:0] TOK_HUNDRED  = 7'd91;
	localparam logic [TokBits-1:0] TOK_THOUSAND = 7'd92;
	localparam logic [TokBits-1:0] TOK_MILLION  = 7'd93;
	localparam logic [TokBits-1:0] TOK_BILLION  = 7'd94;
	localparam logic [TokBits-1:0] TOK_AND      = 7'd95;
	localparam logic [TokBits-1:0] TOK_COMMA    = 7'd96;

	localparam logic [PcBits-1:0] PC_CONV  = 4'd0;
	localparam logic [PcBits-1:0] PC_GROUP = 4'd2;
	localparam logic [PcBits-1:0] PC_ZERO  = 4'd10;

	typedef enum logic [2:0] {
		OP_CONV,
		OP_SEEK,
		OP_EMIT,
		OP_NEXT,
		OP_DONE
	} op_t;

	typedef enum logic [2:0] {
		TS_HDIG,
		TS_HUNDRED,
		TS_AND,
		TS_TENS,
		TS_UNITS,
		TS_SCOPE,
		TS_DELIM,
		TS_ZERO
	} tsel_t;

	typedef enum logic [2:0] {
		C_ALWAYS,
		C_HNZ,
		C_REM,
		C_TNZ,
		C_UOK,
		C_GNZ,
		C_NLOW
	} cond_t;

	typedef enum logic [2:0] {
		LC_NEVER,
		LC_ALWAYS,
		LC_HWORD,
		LC_TENS,
		LC_UNITS,
		LC_SCOPE
	} lastc_t;

	typedef struct packed {
		op_t               op;
		tsel_t             tsel;
		cond_t             cond;
		lastc_t            lastc;
		logic [PcBits-1:0] jaddr;
	} uop_t;

	function automatic uop_t uop_rom(input logic [PcBits-1:0] pc);
		uop_t u;
		case (pc)
			4'd0:    u = '{OP_CONV, TS_ZERO,    C_ALWAYS, LC_NEVER,  PC_CONV};
			4'd1:    u = '{OP_SEEK, TS_ZERO,    C_ALWAYS, LC_NEVER,  PC_ZERO};
			4'd2:    u = '{OP_EMIT, TS_HDIG,    C_HNZ,    LC_NEVER,  PC_CONV};
			4'd3:    u = '{OP_EMIT, TS_HUNDRED, C_HNZ,    LC_HWORD,  PC_CONV};
			4'd4:    u = '{OP_EMIT, TS_AND,     C_REM,    LC_NEVER,  PC_CONV};
			4'd5:    u = '{OP_EMIT, TS_TENS,    C_TNZ,    LC_TENS,   PC_CONV};
			4'd6:    u = '{OP_EMIT, TS_UNITS,   C_UOK,    LC_UNITS,  PC_CONV};
			4'd7:    u = '{OP_EMIT, TS_SCOPE,   C_GNZ,    LC_SCOPE,  PC_CONV};
			4'd8:    u = '{OP_EMIT, TS_DELIM,   C_NLOW,   LC_NEVER,  PC_CONV};
			4'd9:    u = '{OP_NEXT, TS_ZERO,    C_ALWAYS, LC_NEVER,  PC_GROUP};
			4'd10:   u = '{OP_EMIT, TS_ZERO,    C_ALWAYS, LC_ALWAYS, PC_CONV};
			default: u = '{OP_DONE, TS_ZERO,    C_ALWAYS, LC_NEVER,  PC_CONV};
		endcase
		return u;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/nte_if.sv =====
// nte_if: valid/ready channel interfaces for the number input and token output.
// Depends on nte_pkg for payload widths.
`timescale 1ns / 1ps
`default_nettype none
interface nte_in_if import nte_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [NumBits-1:0] number;

	modport source(output valid, output number, input ready);
	modport sink(input valid, input number, output ready);
endinterface

interface nte_out_if import nte_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [TokBits-1:0] token;
	logic               last;

	modport source(output valid, output token, output last, input ready);
	modport sink(input valid, input token, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/nte_bcd.sv =====
// nte_bcd: serial binary to BCD converter (shift and add 3), one bit per cycle.
// Depends on nte_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nte_bcd import nte_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [NumBits-1:0] number,
	output logic                    busy,
	output logic [BcdBits-1:0]      bcd
);

	logic [NumBits-1:0]         bin_q;
	logic [BcdBits-1:0]         bcd_q;
	logic [BcdBits-1:0]         adj;
	logic [CntBits-1:0]         cnt_q;
	logic                       busy_q;

	always_comb begin
		for (int d = 0; d < NumDigs; d++) begin
			if (bcd_q[4*d +: 4] >= 4'd5) begin
				adj[4*d +: 4] = bcd_q[4*d +: 4] + 4'd3;
			end else begin
				adj[4*d +: 4] = bcd_q[4*d +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CntBits'(NumBits - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= number;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[NumBits-2:0], 1'b0};
			bcd_q <= {adj[BcdBits-2:0], bin_q[NumBits-1]};
		end
	end

	assign busy = busy_q;
	assign bcd  = bcd_q;

endmodule
`default_nettype wire

// ===== rtl/core/number_to_english_tokens.sv =====
// number_to_english_tokens: spells a 32-bit unsigned number as word tokens.
// The first token is registered after serial BCD conversion, two setup steps (conversion
// and seek), then any skipped token steps; a token step stalls while dout holds a token and is not ready.
// A new number is accepted only when the sequencer is idle, after the last thousands group
// (or the zero token) has been stepped through.
// Reset: arst_n clears the sequencer, converter and output valid; payload is not reset.
// Depends on nte_pkg, nte_if, nte_bcd.
`timescale 1ns / 1ps
`default_nettype none
module number_to_english_tokens import nte_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	nte_in_if.sink     din,
	nte_out_if.source  dout
);

	logic [PcBits-1:0]  pc_q;
	logic [1:0]         g_q;
	logic               busy_q;
	logic               out_valid_q;
	logic [TokBits-1:0] token_q;
	logic               last_q;

	logic               conv_start;
	logic               conv_busy;
	logic [BcdBits-1:0] bcd;

	uop_t               uw;
	logic [3:0]         hd, td, ud;
	logic [3:0]         nz;
	logic [1:0]         hi_g, lo_g, nl_g;
	logic               nl_any;
	logic               lo_ok;
	logic               lowest;
	logic               emit_c;
	logic               last_c;
	logic [TokBits-1:0] tok;
	logic               can_load;
	logic               load;

	assign conv_start = din.valid && !busy_q;
	assign din.ready  = !busy_q;

	nte_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (conv_start),
		.number (din.number),
		.busy   (conv_busy),
		.bcd    (bcd)
	);

	assign uw = uop_rom(pc_q);

	always_comb begin
		case (g_q)
			2'd0: begin hd = bcd[11:8];  td = bcd[7:4];   ud = bcd[3:0];   end
			2'd1: begin hd = bcd[23:20]; td = bcd[19:16]; ud = bcd[15:12]; end
			2'd2: begin hd = bcd[35:32]; td = bcd[31:28]; ud = bcd[27:24]; end
			default: begin hd = 4'd0; td = 4'd0; ud = bcd[39:36]; end
		endcase
	end

	assign nz[0] = |bcd[11:0];
	assign nz[1] = |bcd[23:12];
	assign nz[2] = |bcd[35:24];
	assign nz[3] = |bcd[39:36];

	always_comb begin
		hi_g   = 2'd0;
		lo_g   = 2'd0;
		nl_g   = 2'd0;
		nl_any = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (nz[i]) begin
				hi_g = 2'(i);
			end
			if (nz[3-i]) begin
				lo_g = 2'(3 - i);
			end
			if (nz[i] && (2'(i) < g_q)) begin
				nl_g   = 2'(i);
				nl_any = 1'b1;
			end
		end
	end

	// lowest group below one hundred or a whole number of hundreds
	always_comb begin
		case (lo_g)
			2'd0: lo_ok = (bcd[11:8] == 4'd0) || (bcd[7:0] == 8'd0);
			2'd1: lo_ok = (bcd[23:20] == 4'd0) || (bcd[19:12] == 8'd0);
			2'd2: lo_ok = (bcd[35:32] == 4'd0) || (bcd[31:24] == 8'd0);
			default: lo_ok = 1'b1;
		endcase
	end

	assign lowest = (g_q == lo_g);

	always_comb begin
		case (uw.cond)
			C_ALWAYS: emit_c = 1'b1;
			C_HNZ:    emit_c = (hd != 4'd0);
			C_REM:    emit_c = (hd != 4'd0) && ((td != 4'd0) || (ud != 4'd0));
			C_TNZ:    emit_c = (td != 4'd0);
			C_UOK:    emit_c = (ud != 4'd0) && (td != 4'd1);
			C_GNZ:    emit_c = (g_q != 2'd0);
			C_NLOW:   emit_c = !lowest;
			default:  emit_c = 1'b0;
		endcase
	end

	always_comb begin
		case (uw.lastc)
			LC_NEVER:  last_c = 1'b0;
			LC_ALWAYS: last_c = 1'b1;
			LC_HWORD:  last_c = lowest && (g_q == 2'd0) && (td == 4'd0) && (ud == 4'd0);
			LC_TENS:   last_c = lowest && (g_q == 2'd0) && ((td == 4'd1) || (ud == 4'd0));
			LC_UNITS:  last_c = lowest && (g_q == 2'd0);
			LC_SCOPE:  last_c = lowest;
			default:   last_c = 1'b0;
		endcase
	end

	always_comb begin
		case (uw.tsel)
			TS_HDIG:    tok = {3'b000, hd};
			TS_HUNDRED: tok = TOK_HUNDRED;
			TS_AND:     tok = TOK_AND;
			TS_TENS: begin
				if (td == 4'd1) begin
					tok = TOK_TEN + {3'b000, ud};
				end else begin
					tok = {3'b000, td} * TOK_TEN;
				end
			end
			TS_UNITS:   tok = {3'b000, ud};
			TS_SCOPE: begin
				case (g_q)
					2'd1:    tok = TOK_THOUSAND;
					2'd2:    tok = TOK_MILLION;
					default: tok = TOK_BILLION;
				endcase
			end
			TS_DELIM:   tok = ((nl_g == lo_g) && lo_ok) ? TOK_AND : TOK_COMMA;
			TS_ZERO:    tok = TOK_ZERO;
			default:    tok = TOK_ZERO;
		endcase
	end

	assign can_load = !out_valid_q || dout.ready;
	assign load     = busy_q && (uw.op == OP_EMIT) && emit_c && can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= PC_CONV;
			g_q    <= 2'd0;
		end else if (!busy_q) begin
			if (din.valid) begin
				busy_q <= 1'b1;
				pc_q   <= PC_CONV;
			end
		end else begin
			case (uw.op)
				OP_CONV: begin
					if (!conv_busy) begin
						pc_q <= pc_q + 1'b1;
					end
				end
				OP_SEEK: begin
					if (nz == 4'd0) begin
						pc_q <= uw.jaddr;
					end else begin
						g_q  <= hi_g;
						pc_q <= pc_q + 1'b1;
					end
				end
				OP_EMIT: begin
					if (!emit_c || can_load) begin
						pc_q <= pc_q + 1'b1;
					end
				end
				OP_NEXT: begin
					if (nl_any) begin
						g_q  <= nl_g;
						pc_q <= uw.jaddr;
					end else begin
						busy_q <= 1'b0;
						pc_q   <= PC_CONV;
					end
				end
				default: begin
					busy_q <= 1'b0;
					pc_q   <= PC_CONV;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			token_q <= tok;
			last_q  <= last_c;
		end
	end

	assign dout.valid = out_valid_q;
	assign dout.token = token_q;
	assign dout.last  = last_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(din.valid && din.ready) |=> (busy_q && conv_busy && (pc_q == PC_CONV)))
		else $error("accepted number did not start conversion");

	a_idle_pc: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (pc_q == PC_CONV))
		else $error("sequencer idle away from entry step");

	a_conv_owned: assert property (@(posedge clk) disable iff (!arst_n)
		conv_busy |-> (busy_q && (pc_q == PC_CONV)))
		else $error("converter running outside conversion step");

	a_token_range: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (tok <= TOK_COMMA))
		else $error("token code out of range");

endmodule
`default_nettype wire
